[hdl/hfft_pkg.sv]
// shared constants, codes and types for the halfedge face fan triangulator
// no dependencies; imported by the channel interfaces and the top level
`timescale 1ns / 1ps

package hfft_pkg;

	localparam int unsigned KIND_W    = 2;
	localparam int unsigned INDEX_W   = 16;
	localparam int unsigned LINK_W    = 32;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned ID_W      = 16;
	localparam int unsigned COUNT_W   = 17;
	localparam int unsigned TOTAL_W   = 32;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [LINK_W-1:0]  NONE_MARK   = '1;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 17'd1;
	localparam int unsigned        MIN_CORNERS = 3;

	localparam int unsigned HALFEDGE_DEPTH_DEF = 65536;
	localparam int unsigned FACE_DEPTH_DEF     = 65536;
	localparam int unsigned MAX_DEGREE_DEF     = 32;

	typedef enum logic [KIND_W-1:0] {
		KIND_HE_WRITE    = 2'd0,
		KIND_FACE_WRITE  = 2'd1,
		KIND_TRIANGULATE = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_TRI     = 2'd0,
		STATUS_SKIP    = 2'd1,
		STATUS_INVALID = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VERTEX_COUNT   = 2'd0,
		REG_HALFEDGE_COUNT = 2'd1,
		REG_FACE_COUNT     = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_FIRST = 3'd1,
		ST_WALK  = 3'd2,
		ST_APEX  = 3'd3,
		ST_EMIT  = 3'd4
	} state_t;

	typedef struct packed {
		status_t             status;
		logic [ID_W-1:0]     c0_vertex;
		logic [ID_W-1:0]     c1_vertex;
		logic [ID_W-1:0]     c2_vertex;
		logic [ID_W-1:0]     c0_halfedge;
		logic [ID_W-1:0]     c1_halfedge;
		logic [ID_W-1:0]     c2_halfedge;
		logic [ID_W-1:0]     face_id;
		logic                last;
		logic [TOTAL_W-1:0]  total;
	} result_t;

endpackage

[hdl/hfft_if.sv]
// valid/ready channel interfaces: input items, result items, register writes
// depends on hfft_pkg for field widths
`timescale 1ns / 1ps

interface hfft_item_if import hfft_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [INDEX_W-1:0]  index;
	logic [LINK_W-1:0]   target_vertex;
	logic [LINK_W-1:0]   next_link;
	logic [LINK_W-1:0]   owner_face;
	logic [LINK_W-1:0]   first_link;

	modport source(output valid, kind, index, target_vertex, next_link, owner_face,
		first_link, input ready);
	modport sink(input valid, kind, index, target_vertex, next_link, owner_face,
		first_link, output ready);
endinterface

interface hfft_result_if import hfft_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [ID_W-1:0]      corner0_vertex;
	logic [ID_W-1:0]      corner1_vertex;
	logic [ID_W-1:0]      corner2_vertex;
	logic [ID_W-1:0]      corner0_halfedge;
	logic [ID_W-1:0]      corner1_halfedge;
	logic [ID_W-1:0]      corner2_halfedge;
	logic [ID_W-1:0]      face_id;
	logic                 last;
	logic [TOTAL_W-1:0]   triangle_total;

	modport source(output valid, status, corner0_vertex, corner1_vertex, corner2_vertex,
		corner0_halfedge, corner1_halfedge, corner2_halfedge, face_id, last,
		triangle_total, input ready);
	modport sink(input valid, status, corner0_vertex, corner1_vertex, corner2_vertex,
		corner0_halfedge, corner1_halfedge, corner2_halfedge, face_id, last,
		triangle_total, output ready);
endinterface

interface hfft_cfg_if import hfft_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [COUNT_W-1:0]    data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[hdl/halfedge_face_fan_triangulator.sv]
// write items are taken while idle. a triangulate item reads and checks the face entry,
// then walks the ring at one halfedge per cycle (one read of the halfedge memory each),
// fetches the second corner and emits one triangle per cycle, while the output register
// is free. the single read port of the halfedge memory sets the walk rate; a full output
// register stalls the sequencer. arst_n clears the state, output valid, triangle count and
// the count registers (to 1); table contents are undefined until written.
`timescale 1ns / 1ps

module halfedge_face_fan_triangulator
	import hfft_pkg::*;
#(
	parameter int unsigned HALFEDGE_DEPTH = HALFEDGE_DEPTH_DEF,
	parameter int unsigned FACE_DEPTH     = FACE_DEPTH_DEF,
	parameter int unsigned MAX_DEGREE     = MAX_DEGREE_DEF
) (
	input logic          clk,
	input logic          arst_n,
	hfft_item_if.sink    item,
	hfft_result_if.source result,
	hfft_cfg_if.sink     cfg
);

	localparam int unsigned HE_AW      = $clog2(HALFEDGE_DEPTH);
	localparam int unsigned HC_W       = $clog2(HALFEDGE_DEPTH + 1);
	localparam int unsigned FA_AW      = (FACE_DEPTH > 1) ? $clog2(FACE_DEPTH) : 1;
	localparam int unsigned FC_W       = $clog2(FACE_DEPTH + 1);
	localparam int unsigned RI_W       = $clog2(MAX_DEGREE);
	localparam int unsigned CNT_W      = $clog2(MAX_DEGREE + 1);
	localparam int unsigned HE_ENTRY_W = 3 * LINK_W;
	localparam int unsigned CORNER_W   = 2 * ID_W;

	// storage
	logic [HE_ENTRY_W-1:0] he_mem [HALFEDGE_DEPTH];
	logic [LINK_W-1:0]     face_mem [FACE_DEPTH];
	logic [CORNER_W-1:0]   ring_mem [MAX_DEGREE];

	logic [HE_ENTRY_W-1:0] he_rd_q;
	logic [LINK_W-1:0]     face_rd_q;
	logic [CORNER_W-1:0]   ring_rd_q;

	// control and working registers
	state_t               state_q, state_d;
	logic [COUNT_W-1:0]   vcount_q, hcount_q, fcount_q;
	logic [TOTAL_W-1:0]   tri_cnt_q;
	logic                 out_valid_q;
	result_t              out_q, res_d;
	logic [ID_W-1:0]      face_q;
	logic [HE_AW-1:0]     he_q, he_d;
	logic [HE_AW-1:0]     first_q, first_d;
	logic [CNT_W-1:0]     n_q, n_d, n_inc;
	logic [CNT_W-1:0]     i_q, i_d;
	logic [CORNER_W-1:0]  apex_q, apex_d;
	logic [CORNER_W-1:0]  side_q, side_d;

	logic                 item_acc;
	logic                 he_we, face_we;
	logic [FA_AW-1:0]     face_ra;
	logic                 ring_we;
	logic [RI_W-1:0]      ring_ra;
	logic                 res_load, res_free, tri_inc, last_tri;
	logic [HC_W-1:0]      hc_w;
	logic [FC_W-1:0]      fc_w;
	logic [LINK_W-1:0]    tgt, nx, own;

	assign item.ready = (state_q == ST_IDLE);
	assign item_acc   = item.valid && item.ready;
	assign cfg.ready  = 1'b1;
	assign res_free   = !out_valid_q || result.ready;

	// effective counts, clamped to the table depths
	assign hc_w = (32'(hcount_q) < 32'(HALFEDGE_DEPTH)) ? HC_W'(hcount_q)
		: HC_W'(HALFEDGE_DEPTH);
	assign fc_w = (32'(fcount_q) < 32'(FACE_DEPTH)) ? FC_W'(fcount_q) : FC_W'(FACE_DEPTH);

	assign tgt = he_rd_q[LINK_W-1:0];
	assign nx  = he_rd_q[2*LINK_W-1:LINK_W];
	assign own = he_rd_q[3*LINK_W-1:2*LINK_W];

	assign he_we   = item_acc && (item.kind == KIND_HE_WRITE)
		&& (32'(item.index) < 32'(HALFEDGE_DEPTH));
	assign face_we = item_acc && (item.kind == KIND_FACE_WRITE)
		&& (32'(item.index) < 32'(FACE_DEPTH));
	assign face_ra = (state_q == ST_IDLE) ? FA_AW'(item.index) : FA_AW'(face_q);
	assign n_inc   = n_q + CNT_W'(1);

	always_ff @(posedge clk) begin
		if (he_we) begin
			he_mem[HE_AW'(item.index)] <= {item.owner_face, item.next_link, item.target_vertex};
		end
		he_rd_q <= he_mem[he_d];
	end

	always_ff @(posedge clk) begin
		if (face_we) begin
			face_mem[FA_AW'(item.index)] <= item.first_link;
		end
		face_rd_q <= face_mem[face_ra];
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[RI_W'(n_q)] <= {16'(he_q), tgt[ID_W-1:0]};
		end
		ring_rd_q <= ring_mem[ring_ra];
	end

	// sequencer: face check, ring walk, fan emission
	always_comb begin
		state_d  = state_q;
		he_d     = he_q;
		first_d  = first_q;
		n_d      = n_q;
		i_d      = i_q;
		apex_d   = apex_q;
		side_d   = side_q;
		ring_we  = 1'b0;
		ring_ra  = RI_W'(i_q + CNT_W'(1));
		res_load = 1'b0;
		tri_inc  = 1'b0;
		last_tri = (i_q + CNT_W'(2)) == n_q;
		res_d         = '0;
		res_d.status  = STATUS_SKIP;
		res_d.face_id = face_q;
		res_d.last    = 1'b1;
		res_d.total   = tri_cnt_q;

		unique case (state_q)
			ST_IDLE: begin
				if (item_acc && item.kind == KIND_TRIANGULATE) begin
					state_d = ST_FIRST;
				end
			end
			ST_FIRST: begin
				if (res_free) begin
					priority if (32'(face_q) >= 32'(fc_w) || face_rd_q == NONE_MARK) begin
						res_load = 1'b1;
						state_d  = ST_IDLE;
					end else if (face_rd_q >= 32'(hc_w)) begin
						res_d.status = STATUS_INVALID;
						res_load     = 1'b1;
						state_d      = ST_IDLE;
					end else begin
						he_d    = HE_AW'(face_rd_q);
						first_d = HE_AW'(face_rd_q);
						n_d     = '0;
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				if (res_free) begin
					priority if (own != 32'(face_q)) begin
						// a foreign first halfedge means the face is unowned
						res_d.status = (n_q == '0) ? STATUS_SKIP : STATUS_INVALID;
						res_load     = 1'b1;
						state_d      = ST_IDLE;
					end else if (tgt >= 32'(vcount_q) || n_q >= CNT_W'(MAX_DEGREE)) begin
						res_d.status = STATUS_INVALID;
						res_load     = 1'b1;
						state_d      = ST_IDLE;
					end else begin
						ring_we = 1'b1;
						n_d     = n_inc;
						if (n_q == '0) begin
							apex_d = {16'(he_q), tgt[ID_W-1:0]};
						end
						priority if (nx == 32'(first_q)) begin
							if (n_inc < CNT_W'(MIN_CORNERS)) begin
								res_load = 1'b1;
								state_d  = ST_IDLE;
							end else begin
								i_d     = CNT_W'(1);
								ring_ra = RI_W'(1);
								state_d = ST_APEX;
							end
						end else if (nx >= 32'(hc_w) || 32'(n_q) == 32'(hc_w)) begin
							res_d.status = STATUS_INVALID;
							res_load     = 1'b1;
							state_d      = ST_IDLE;
						end else begin
							he_d = HE_AW'(nx);
						end
					end
				end
			end
			ST_APEX: begin
				side_d  = ring_rd_q;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (res_free) begin
					res_d.status      = STATUS_TRI;
					res_d.c0_vertex   = apex_q[ID_W-1:0];
					res_d.c0_halfedge = apex_q[CORNER_W-1:ID_W];
					res_d.c1_vertex   = side_q[ID_W-1:0];
					res_d.c1_halfedge = side_q[CORNER_W-1:ID_W];
					res_d.c2_vertex   = ring_rd_q[ID_W-1:0];
					res_d.c2_halfedge = ring_rd_q[CORNER_W-1:ID_W];
					res_d.last        = last_tri;
					res_d.total       = tri_cnt_q + 32'd1;
					res_load          = 1'b1;
					tri_inc           = 1'b1;
					side_d            = ring_rd_q;
					i_d               = i_q + CNT_W'(1);
					ring_ra           = RI_W'(i_q + CNT_W'(2));
					if (last_tri) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			tri_cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (tri_inc) begin
				tri_cnt_q <= tri_cnt_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= COUNT_RESET;
			hcount_q <= COUNT_RESET;
			fcount_q <= COUNT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (reg_idx_t'(cfg.index))
				REG_VERTEX_COUNT:   vcount_q <= cfg.data;
				REG_HALFEDGE_COUNT: hcount_q <= cfg.data;
				REG_FACE_COUNT:     fcount_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			face_q <= item.index;
		end
		he_q    <= he_d;
		first_q <= first_d;
		n_q     <= n_d;
		i_q     <= i_d;
		apex_q  <= apex_d;
		side_q  <= side_d;
		if (res_load) begin
			out_q <= res_d;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.status           = out_q.status;
	assign result.corner0_vertex   = out_q.c0_vertex;
	assign result.corner1_vertex   = out_q.c1_vertex;
	assign result.corner2_vertex   = out_q.c2_vertex;
	assign result.corner0_halfedge = out_q.c0_halfedge;
	assign result.corner1_halfedge = out_q.c1_halfedge;
	assign result.corner2_halfedge = out_q.c2_halfedge;
	assign result.face_id          = out_q.face_id;
	assign result.last             = out_q.last;
	assign result.triangle_total   = out_q.total;

	// skip and invalid beats close the item and carry no corners
	a_status_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != STATUS_TRI
		|-> out_q.last && out_q.c0_vertex == '0 && out_q.c2_halfedge == '0)
		else $error("status beat without last or with corner data");

	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && res_d.status == STATUS_TRI |=> tri_cnt_q == $past(tri_cnt_q) + 32'd1)
		else $error("triangle count did not advance with a triangle beat");

	a_total_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!tri_inc |=> $stable(tri_cnt_q))
		else $error("triangle count moved without a triangle");

	a_ring_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK || state_q == ST_EMIT |-> n_q <= CNT_W'(MAX_DEGREE))
		else $error("ring corner count beyond buffer depth");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && res_d.last |=> state_q == ST_IDLE)
		else $error("sequencer still busy after the closing beat");

endmodule

[verif/tb_halfedge_face_fan_triangulator.sv]
// self-checking testbench for the halfedge face fan triangulator: loads rings, triangulates
// faces and checks every result beat against a predicted triangle fan
// depends on hfft_pkg, the hfft channel interfaces and the top level in hdl/
`timescale 1ns / 1ps

module tb_halfedge_face_fan_triangulator;
	import hfft_pkg::*;

	localparam int unsigned HE_DEPTH   = HALFEDGE_DEPTH_DEF;
	localparam int unsigned FACE_DEPTH = FACE_DEPTH_DEF;
	localparam int unsigned MAXD       = MAX_DEGREE_DEF;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned SETTLE      = 24;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef enum int {
		FLAW_NONE,
		FLAW_NEXT_NONE,
		FLAW_OWNER,
		FLAW_TARGET,
		FLAW_OPEN,
		FLAW_NEXT_RANGE,
		FLAW_FIRST_NONE,
		FLAW_FIRST_RANGE,
		FLAW_FIRST_OWNER,
		FLAW_COUNT
	} flaw_t;

	class fan_checker;
		logic [31:0] tgt_mem [HE_DEPTH];
		logic [31:0] next_mem [HE_DEPTH];
		logic [31:0] owner_mem [HE_DEPTH];
		logic [31:0] first_mem [FACE_DEPTH];
		bit he_seen [HE_DEPTH];
		bit face_seen [FACE_DEPTH];
		logic [15:0] ring_v [MAXD];
		logic [15:0] ring_h [MAXD];
		int unsigned corners;
		bit miss;
		bit miss_face;
		logic [15:0] miss_idx;
		logic [COUNT_W-1:0] vcount = COUNT_RESET;
		logic [COUNT_W-1:0] hcount = COUNT_RESET;
		logic [COUNT_W-1:0] fcount = COUNT_RESET;
		logic [TOTAL_W-1:0] tri_total = '0;
		result_t fan_queue [$];
		int errors = 0;

		function int unsigned eff_he();
			return (hcount > HE_DEPTH) ? HE_DEPTH : hcount;
		endfunction

		function int unsigned eff_face();
			return (fcount > FACE_DEPTH) ? FACE_DEPTH : fcount;
		endfunction

		function void set_reg(reg_idx_t r, logic [COUNT_W-1:0] v);
			case (r)
				REG_VERTEX_COUNT: vcount = v;
				REG_HALFEDGE_COUNT: hcount = v;
				REG_FACE_COUNT: fcount = v;
				default: ;
			endcase
		endfunction

		function void queue_beat(result_t r);
			fan_queue.insert(fan_queue.size(), r);
		endfunction

		// follows the ring of a face; flags the first unwritten entry it would read
		function status_t walk_ring(logic [15:0] face);
			int unsigned hc;
			int unsigned step;
			logic [31:0] first;
			logic [31:0] he;
			logic [31:0] nx;
			hc = eff_he();
			corners = 0;
			if (!face_seen[face]) begin
				miss = 1'b1;
				miss_face = 1'b1;
				miss_idx = face;
				return STATUS_SKIP;
			end
			first = first_mem[face];
			if (first == NONE_MARK)
				return STATUS_SKIP;
			if (first >= hc)
				return STATUS_INVALID;
			if (!he_seen[first[15:0]]) begin
				miss = 1'b1;
				miss_face = 1'b0;
				miss_idx = first[15:0];
				return STATUS_SKIP;
			end
			if (owner_mem[first[15:0]] != {16'h0, face})
				return STATUS_SKIP;
			he = first;
			step = 0;
			while (1) begin
				if (he >= hc)
					return STATUS_INVALID;
				if (!he_seen[he[15:0]]) begin
					miss = 1'b1;
					miss_face = 1'b0;
					miss_idx = he[15:0];
					return STATUS_INVALID;
				end
				if (owner_mem[he[15:0]] != {16'h0, face})
					return STATUS_INVALID;
				if (tgt_mem[he[15:0]] >= vcount)
					return STATUS_INVALID;
				if (corners >= MAXD)
					return STATUS_INVALID;
				ring_v[corners] = tgt_mem[he[15:0]][15:0];
				ring_h[corners] = he[15:0];
				corners++;
				nx = next_mem[he[15:0]];
				if (nx == first)
					break;
				if (nx == NONE_MARK || step == hc)
					return STATUS_INVALID;
				he = nx;
				step++;
			end
			return (corners < MIN_CORNERS) ? STATUS_SKIP : STATUS_TRI;
		endfunction

		function bit walk_is_safe(logic [15:0] face);
			miss = 1'b0;
			if (face < eff_face())
				void'(walk_ring(face));
			return !miss;
		endfunction

		function void note_item(logic [KIND_W-1:0] k, logic [15:0] idx, logic [31:0] tv,
				logic [31:0] nl, logic [31:0] of, logic [31:0] fl);
			result_t r;
			status_t st;
			int unsigned i;
			case (k)
				KIND_HE_WRITE: begin
					tgt_mem[idx] = tv;
					next_mem[idx] = nl;
					owner_mem[idx] = of;
					he_seen[idx] = 1'b1;
				end
				KIND_FACE_WRITE: begin
					first_mem[idx] = fl;
					face_seen[idx] = 1'b1;
				end
				KIND_TRIANGULATE: begin
					miss = 1'b0;
					if (idx >= eff_face())
						st = STATUS_SKIP;
					else
						st = walk_ring(idx);
					if (st != STATUS_TRI) begin
						r = '0;
						r.status = st;
						r.face_id = idx;
						r.last = 1'b1;
						r.total = tri_total;
						queue_beat(r);
					end else begin
						for (i = 1; i + 1 < corners; i++) begin
							tri_total++;
							r.status = STATUS_TRI;
							r.c0_vertex = ring_v[0];
							r.c1_vertex = ring_v[i];
							r.c2_vertex = ring_v[i + 1];
							r.c0_halfedge = ring_h[0];
							r.c1_halfedge = ring_h[i];
							r.c2_halfedge = ring_h[i + 1];
							r.face_id = idx;
							r.last = (i + 2 == corners);
							r.total = tri_total;
							queue_beat(r);
						end
					end
				end
				default: ;
			endcase
		endfunction

		function string fan_text(result_t r);
			return $sformatf("st=%0d v=%h,%h,%h he=%h,%h,%h face=%h last=%b total=%h",
				r.status, r.c0_vertex, r.c1_vertex, r.c2_vertex, r.c0_halfedge,
				r.c1_halfedge, r.c2_halfedge, r.face_id, r.last, r.total);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (fan_queue.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat: %s", fan_text(got));
				return;
			end
			want = fan_queue.pop_front();
			if (got.status !== want.status || got.c0_vertex !== want.c0_vertex ||
					got.c1_vertex !== want.c1_vertex || got.c2_vertex !== want.c2_vertex ||
					got.c0_halfedge !== want.c0_halfedge ||
					got.c1_halfedge !== want.c1_halfedge ||
					got.c2_halfedge !== want.c2_halfedge || got.face_id !== want.face_id ||
					got.last !== want.last || got.total !== want.total) begin
				errors++;
				if (errors <= 10) begin
					$display("result beat differs, expected %s", fan_text(want));
					$display("                     actual   %s", fan_text(got));
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit hold_req = 1'b0;
	bit calm = 1'b0;
	int items_sent = 0;
	int case_no = 0;
	int unsigned idle_cycles = 0;
	fan_checker sb = new();

	hfft_item_if item_ch();
	hfft_result_if result_ch();
	hfft_cfg_if cfg_ch();

	halfedge_face_fan_triangulator dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// valid stays high between back-to-back beats; only a gap lowers it
	task automatic send_item(input logic [KIND_W-1:0] k, input logic [15:0] idx,
			input logic [31:0] tv, input logic [31:0] nl, input logic [31:0] of,
			input logic [31:0] fl);
		item_ch.valid <= 1'b1;
		item_ch.kind <= k;
		item_ch.index <= idx;
		item_ch.target_vertex <= tv;
		item_ch.next_link <= nl;
		item_ch.owner_face <= of;
		item_ch.first_link <= fl;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_item(k, idx, tv, nl, of, fl);
		if (k != KIND_UNUSED)
			items_sent++;
		if (!calm && $urandom_range(0, 5) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (sb.fan_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t r, input logic [COUNT_W-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= r;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_reg(r, v);
	endtask

	task automatic set_counts(input int unsigned v, input int unsigned h, input int unsigned f);
		drain();
		write_reg(REG_VERTEX_COUNT, COUNT_W'(v));
		write_reg(REG_HALFEDGE_COUNT, COUNT_W'(h));
		write_reg(REG_FACE_COUNT, COUNT_W'(f));
		cfg_ch.valid <= 1'b0;
	endtask

	// fills in whatever entry the walk would read unwritten, then sends the triangulate
	task automatic triangulate(input logic [15:0] face);
		int tries;
		for (tries = 0; tries < 6; tries++) begin
			if (sb.walk_is_safe(face)) begin
				send_item(KIND_TRIANGULATE, face, $urandom(), $urandom(), $urandom(),
					$urandom());
				return;
			end
			if (sb.miss_face)
				send_item(KIND_FACE_WRITE, face, $urandom(), $urandom(), $urandom(),
					($urandom_range(0, 3) == 0) ? NONE_MARK : $urandom_range(0, 63));
			else
				send_item(KIND_HE_WRITE, sb.miss_idx,
					(sb.vcount != 0) ? $urandom_range(0, sb.vcount - 1) : $urandom(),
					$urandom_range(0, 63), {16'h0, face}, $urandom());
		end
	endtask

	task automatic fan_case(input logic [15:0] face, input int unsigned n, input flaw_t flaw);
		int unsigned hc;
		int unsigned pool;
		int unsigned p;
		int unsigned j;
		int unsigned k;
		int unsigned tmp;
		int unsigned slot [];
		logic [31:0] he_ix [MAXD + 2];
		logic [31:0] tgt [MAXD + 2];
		logic [31:0] nxt [MAXD + 2];
		logic [31:0] own [MAXD + 2];
		logic [31:0] first;
		hc = sb.eff_he();
		pool = (hc > 256) ? 256 : hc;
		if (pool < n)
			pool = n;
		slot = new[pool];
		for (j = 0; j < pool; j++)
			slot[j] = j;
		for (j = 0; j < n; j++) begin
			k = $urandom_range(j, pool - 1);
			tmp = slot[j];
			slot[j] = slot[k];
			slot[k] = tmp;
			he_ix[j] = slot[j];
		end
		for (j = 0; j < n; j++) begin
			tgt[j] = (sb.vcount != 0) ? $urandom_range(0, sb.vcount - 1) : $urandom();
			nxt[j] = he_ix[(j + 1) % n];
			own[j] = {16'h0, face};
		end
		first = he_ix[0];
		p = $urandom_range(0, n - 1);
		case (flaw)
			FLAW_NEXT_NONE: nxt[p] = NONE_MARK;
			FLAW_OWNER: own[p] = {16'h0, face} ^ (32'h1 << $urandom_range(0, 31));
			FLAW_TARGET: tgt[p] = ($urandom_range(0, 1) == 0) ? NONE_MARK :
				($urandom() | 32'h8000_0000);
			FLAW_OPEN: if (n >= 2) nxt[n - 1] = he_ix[$urandom_range(1, n - 1)];
			FLAW_NEXT_RANGE: nxt[p] = hc + $urandom_range(0, 4095);
			FLAW_FIRST_NONE: first = NONE_MARK;
			FLAW_FIRST_RANGE: first = hc + $urandom_range(0, 4095);
			FLAW_FIRST_OWNER: own[0] = {16'h0, face} ^ (32'h1 << $urandom_range(0, 31));
			default: ;
		endcase
		for (j = 0; j < n; j++)
			send_item(KIND_HE_WRITE, he_ix[j][15:0], tgt[j], nxt[j], own[j], $urandom());
		send_item(KIND_FACE_WRITE, face, $urandom(), $urandom(), $urandom(), first);
		triangulate(face);
	endtask

	task automatic run_mix(input int count);
		int goal;
		int unsigned r;
		int unsigned fc;
		int unsigned n;
		flaw_t flaw;
		logic [15:0] face;
		goal = items_sent + count;
		while (items_sent < goal) begin
			r = $urandom_range(0, 99);
			fc = sb.eff_face();
			if (r < 70) begin
				if (fc == 0)
					face = 16'($urandom());
				else if ($urandom_range(0, 9) == 0)
					face = 16'($urandom_range(0, fc - 1));
				else
					face = 16'($urandom_range(0, ((fc > 64) ? 64 : fc) - 1));
				r = $urandom_range(0, 99);
				if (r < 10)
					n = $urandom_range(1, 2);
				else if (r < 75)
					n = $urandom_range(3, 8);
				else if (r < 93)
					n = $urandom_range(9, MAXD - 1);
				else
					n = $urandom_range(MAXD, MAXD + 2);
				flaw = ($urandom_range(0, 9) < 6) ? FLAW_NONE :
					flaw_t'($urandom_range(1, FLAW_COUNT - 1));
				// the first ring cases walk through every flaw, then the largest rings
				if (case_no < FLAW_COUNT) begin
					flaw = flaw_t'(case_no);
					n = $urandom_range(3, 8);
				end else if (case_no == FLAW_COUNT) begin
					flaw = FLAW_NONE;
					n = MAXD;
				end else if (case_no == FLAW_COUNT + 1) begin
					flaw = FLAW_NONE;
					n = MAXD + 1;
				end
				case_no++;
				fan_case(face, n, flaw);
			end else if (r < 78) begin
				send_item(KIND_HE_WRITE, 16'($urandom()),
					($urandom_range(0, 3) == 0) ? NONE_MARK : $urandom(),
					($urandom_range(0, 3) == 0) ? NONE_MARK : $urandom(),
					($urandom_range(0, 3) == 0) ? NONE_MARK : $urandom(), $urandom());
			end else if (r < 85) begin
				send_item(KIND_FACE_WRITE, 16'($urandom()), $urandom(), $urandom(),
					$urandom(), ($urandom_range(0, 3) == 0) ? NONE_MARK : $urandom());
			end else if (r < 95) begin
				if (fc == 0 || $urandom_range(0, 2) == 0)
					face = 16'($urandom());
				else
					face = 16'($urandom_range(0, fc + 3));
				triangulate(face);
			end else begin
				send_item(KIND_UNUSED, 16'($urandom()), $urandom(), $urandom(), $urandom(),
					$urandom());
			end
		end
	endtask

	always @(posedge clk) begin : result_mon
		result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.status = status_t'(result_ch.status);
			got.c0_vertex = result_ch.corner0_vertex;
			got.c1_vertex = result_ch.corner1_vertex;
			got.c2_vertex = result_ch.corner2_vertex;
			got.c0_halfedge = result_ch.corner0_halfedge;
			got.c1_halfedge = result_ch.corner1_halfedge;
			got.c2_halfedge = result_ch.corner2_halfedge;
			got.face_id = result_ch.face_id;
			got.last = result_ch.last;
			got.total = result_ch.triangle_total;
			sb.check_result(got);
		end
	end

	initial begin : result_sink
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// no beat on any channel for too long means the block is hung
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) ||
				(result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("halfedge_face_fan_triangulator: mismatch");
			$finish;
		end
	end

	initial begin : stim
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.kind = '0;
		item_ch.index = '0;
		item_ch.target_vertex = '0;
		item_ch.next_link = '0;
		item_ch.owner_face = '0;
		item_ch.first_link = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_VERTEX_COUNT;
		cfg_ch.data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_counts(65536, 64, 16);
		send_item(KIND_UNUSED, 16'hFFFF, NONE_MARK, NONE_MARK, NONE_MARK, NONE_MARK);
		send_item(KIND_HE_WRITE, 16'hFFFF, NONE_MARK, NONE_MARK, NONE_MARK, NONE_MARK);
		send_item(KIND_FACE_WRITE, 16'hFFFF, NONE_MARK, NONE_MARK, NONE_MARK, NONE_MARK);
		// face beyond face_count
		triangulate(16'hFFFF);
		fan_case(16'd0, 3, FLAW_NONE);
		fan_case(16'd1, 4, FLAW_NONE);
		fan_case(16'd2, 2, FLAW_NONE);
		fan_case(16'd3, 3, FLAW_FIRST_NONE);

		run_mix(20);
		hold_req = 1'b1;
		run_mix(32);

		set_counts(131071, 131071, 65536);
		run_mix(18);
		drain();
		run_mix(18);

		// zero counts: every non-empty face is invalid, or every face is skipped
		set_counts(0, 48, 8);
		run_mix(14);
		set_counts(40, 0, 8);
		run_mix(14);
		set_counts(1, 1, 0);
		run_mix(10);

		set_counts(4096, 100, 131071);
		calm = 1'b1;
		run_mix(48);

		drain();
		sb.errors += sb.fan_queue.size();
		if (sb.errors == 0)
			$display("halfedge_face_fan_triangulator: match");
		else
			$display("halfedge_face_fan_triangulator: mismatch");
		$finish;
	end

endmodule

[filelist.f]
hdl/hfft_pkg.sv
hdl/hfft_if.sv
hdl/halfedge_face_fan_triangulator.sv
verif/tb_halfedge_face_fan_triangulator.sv
